/* sv/fatan_pkg.sv */
// ----------------------------------------------------------------------------
// fatan_pkg
// Shared constants and types for the fast arctangent pipeline.
// ----------------------------------------------------------------------------
package fatan_pkg;

  // pi with 62 fraction bits.
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

  // Coefficient 0.28 as a 16-fraction-bit value.
  localparam logic [14:0] COEF_Q16 = 15'd18350;

  // Magnitudes are scaled until both fit this many bits.
  localparam int unsigned MAG_W = 16;

  // Numerator and denominator widths of the ratio.
  localparam int unsigned NUM_W = 2 * MAG_W + 16;
  localparam int unsigned DEN_W = NUM_W + 1;

  // Per-item sign and branch flags that travel with the data.
  typedef struct packed {
    logic x_zero;
    logic x_neg;
    logic y_neg;
    logic y_zero;
    logic below_diag;
  } flags_t;

endpackage

/* sv/fatan_div_stage.sv */
// ----------------------------------------------------------------------------
// fatan_div_stage
// One restoring-division step of the ratio pipeline, with its register.
// ----------------------------------------------------------------------------
module fatan_div_stage #(
  parameter int unsigned QW = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             vld_i,
  input  fatan_pkg::flags_t                flg_i,
  input  logic [fatan_pkg::DEN_W-1:0]      rem_i,
  input  logic [fatan_pkg::DEN_W-1:0]      den_i,
  input  logic [QW-1:0]                    quo_i,
  output logic                             vld_o,
  output fatan_pkg::flags_t                flg_o,
  output logic [fatan_pkg::DEN_W-1:0]      rem_o,
  output logic [fatan_pkg::DEN_W-1:0]      den_o,
  output logic [QW-1:0]                    quo_o
);

  logic [fatan_pkg::DEN_W:0]   rem2;
  logic [fatan_pkg::DEN_W:0]   diff;
  logic                        ge;
  logic [fatan_pkg::DEN_W-1:0] rem_nxt;

  // The remainder stays below the divisor, so both outcomes fit DEN_W bits.
  always_comb begin
    rem2    = {rem_i, 1'b0};
    diff    = rem2 - {1'b0, den_i};
    ge      = (rem2 >= {1'b0, den_i});
    rem_nxt = ge ? diff[fatan_pkg::DEN_W-1:0] : rem2[fatan_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flg_o <= flg_i;
      rem_o <= rem_nxt;
      den_o <= den_i;
      quo_o <= {quo_i[QW-2:0], ge};
    end
  end

endmodule

/* sv/fast_atan2_approx_unit.sv */
// ----------------------------------------------------------------------------
// fast_atan2_approx_unit
// Pipelined four-quadrant arctangent using the 0.28 rational approximation.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one (x, y) coordinate pair per beat on
// in_x_coord and in_y_coord; a beat is taken when in_valid is high and
// in_stall is low. The result channel returns one angle per beat on
// out_angle, in radians with ANGLE_FRAC_BITS fraction bits, saturated to
// plus or minus pi.
// From input beat to output beat the data passes magnitude scaling, the
// products, the numerator and denominator, one division step per quotient
// bit (ANGLE_FRAC_BITS + 1 of them) and a final stage that rounds, picks
// the quadrant and saturates into the output register.
// Throughput is one beat per cycle while no shown result is held by
// out_stall; every stage is a register with a valid bit, so a new pair may
// enter on each clock that in_stall is low.
// Reset (rst_n low at a clock edge) clears all valid bits, so the pipeline
// comes up empty and no stale result is presented.
// When the receiver holds out_stall while a result is shown, the whole
// pipeline freezes and in_stall is raised in the same cycle; nothing is
// dropped or repeated, and the shown result stays stable.
// ----------------------------------------------------------------------------
module fast_atan2_approx_unit #(
  parameter int unsigned COORD_WIDTH     = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_angle
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned F     = ANGLE_FRAC_BITS;
  localparam int unsigned QW    = F + 1;
  localparam int unsigned RW    = F + 20;
  localparam int unsigned MW    = fatan_pkg::MAG_W;
  localparam int unsigned NW    = fatan_pkg::NUM_W;
  localparam int unsigned DW    = fatan_pkg::DEN_W;
  localparam int unsigned SW    = $clog2(CW + 1);
  localparam int unsigned NDIV  = F + 1;

  // Rounded pi and pi/2 at the output scale.
  localparam logic [63:0] PI_FIX =
    (fatan_pkg::PI_Q62 + (64'd1 << (61 - F))) >> (62 - F);
  localparam logic [63:0] HPI_FIX =
    (fatan_pkg::PI_Q62 + (64'd1 << (62 - F))) >> (63 - F);
  localparam logic signed [RW-1:0] PI_S  = RW'(PI_FIX);
  localparam logic signed [RW-1:0] HPI_S = RW'(HPI_FIX);

  // The whole pipeline advances together unless a shown result is held.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: magnitudes, flags and common scaling into 16 bits.
  logic [CW-1:0]     ax, ay;
  logic [SW-1:0]     sh;
  logic [MW-1:0]     a_nxt, b_nxt;
  fatan_pkg::flags_t f1_nxt;

  always_comb begin
    ax  = in_x_coord[CW-1] ? (~in_x_coord + 1'b1) : in_x_coord;
    ay  = in_y_coord[CW-1] ? (~in_y_coord + 1'b1) : in_y_coord;
    f1_nxt.x_zero     = (in_x_coord == '0);
    f1_nxt.x_neg      = in_x_coord[CW-1];
    f1_nxt.y_neg      = in_y_coord[CW-1];
    f1_nxt.y_zero     = (in_y_coord == '0);
    f1_nxt.below_diag = (ay < ax);
  end

  generate
    if (CW > MW) begin : g_scale
      logic [CW-1:0] mor;
      always_comb begin
        mor = ax | ay;
        sh = '0;
        for (int k = MW; k < CW; k++) begin
          if (mor[k]) sh = SW'(k - MW + 1);
        end
        a_nxt = MW'(ax >> sh);
        b_nxt = MW'(ay >> sh);
      end
    end else begin : g_noscale
      assign sh    = '0;
      assign a_nxt = MW'(ax) >> sh;
      assign b_nxt = MW'(ay) >> sh;
    end
  endgenerate

  logic              v1_r;
  fatan_pkg::flags_t f1_r;
  logic [MW-1:0]     a_r, b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= f1_nxt;
      a_r  <= a_nxt;
      b_r  <= b_nxt;
    end
  end

  // Stage 2: the two squares and the cross product.
  logic              v2_r;
  fatan_pkg::flags_t f2_r;
  logic [2*MW-1:0]   aa_r, bb_r, ab_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r <= f1_r;
      aa_r <= a_r * a_r;
      bb_r <= b_r * b_r;
      ab_r <= a_r * b_r;
    end
  end

  // Stage 3: numerator and denominator. The larger magnitude's square takes
  // the unit weight, the smaller one's the 0.28 weight.
  logic [2*MW-1:0] lsq, ssq;
  logic [2*MW+14:0] wsq;
  logic [DW-1:0]   den_nxt;

  always_comb begin
    lsq     = f2_r.below_diag ? aa_r : bb_r;
    ssq     = f2_r.below_diag ? bb_r : aa_r;
    wsq     = fatan_pkg::COEF_Q16 * ssq;
    den_nxt = DW'({lsq, 16'd0}) + DW'(wsq);
  end

  logic              v3_r;
  fatan_pkg::flags_t f3_r;
  logic [DW-1:0]     num_r, den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_r  <= f2_r;
      num_r <= DW'({ab_r, 16'd0});
      den_r <= den_nxt;
    end
  end

  // Division: the ratio is below one, so only fraction bits are developed,
  // one per stage, with one extra bit for rounding.
  logic              dv  [NDIV+1];
  fatan_pkg::flags_t dfl [NDIV+1];
  logic [DW-1:0]     drem[NDIV+1];
  logic [DW-1:0]     dden[NDIV+1];
  logic [QW-1:0]     dquo[NDIV+1];

  assign dv[0]   = v3_r;
  assign dfl[0]  = f3_r;
  assign drem[0] = num_r;
  assign dden[0] = den_r;
  assign dquo[0] = '0;

  generate
    for (genvar i = 0; i < NDIV; i++) begin : g_div
      fatan_div_stage #(.QW(QW)) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vld_i (dv[i]),
        .flg_i (dfl[i]),
        .rem_i (drem[i]),
        .den_i (dden[i]),
        .quo_i (dquo[i]),
        .vld_o (dv[i+1]),
        .flg_o (dfl[i+1]),
        .rem_o (drem[i+1]),
        .den_o (dden[i+1]),
        .quo_o (dquo[i+1])
      );
    end
  endgenerate

  // Final stage: round half up, apply the sign of z, place the angle in its
  // quadrant and clamp to plus or minus pi.
  fatan_pkg::flags_t      ff;
  logic [QW:0]            qsum;
  logic signed [RW-1:0]   ts, res, sat;
  logic [15:0]            angle_nxt;

  always_comb begin
    ff   = dfl[NDIV];
    qsum = {1'b0, dquo[NDIV]} + 1'b1;
    ts   = RW'(qsum[QW:1]);
    if (ff.x_neg ^ ff.y_neg) ts = -ts;
    if (ff.x_zero) begin
      if (ff.y_zero)     res = '0;
      else if (ff.y_neg) res = -HPI_S;
      else               res = HPI_S;
    end else if (ff.below_diag) begin
      res = ts;
      if (ff.x_neg) res = ff.y_neg ? (res - PI_S) : (res + PI_S);
    end else begin
      res = HPI_S - ts;
      if (ff.y_neg) res = res - PI_S;
    end
    sat = res;
    if (res > PI_S)  sat = PI_S;
    if (res < -PI_S) sat = -PI_S;
    angle_nxt = sat[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle <= angle_nxt;
    end
  end

endmodule

/* bench/fast_atan2_approx_unit_tb.sv */
// ----------------------------------------------------------------------------
// fast_atan2_approx_unit_tb
// Self-checking bench for the pipelined fast arctangent unit.
// ----------------------------------------------------------------------------
// A short table of directed pairs (axes, extremes, diagonals, the origin) is
// sent first. About 1900 random pairs follow, many of them near the branch
// boundary where |y| equals |x|. Every accepted input beat is run through an
// angle predictor, and the expected angle is queued. Each accepted output
// beat is compared with the oldest queued angle. The sender works in bursts,
// and the receiver stalls on a pattern of its own, with one long hold-off
// that fills the pipeline.
// ----------------------------------------------------------------------------
module fast_atan2_approx_unit_tb;

  localparam int unsigned CW = 16;
  localparam int unsigned FB = 13;
  localparam int unsigned LATENCY = FB + 5;
  localparam int unsigned N_RANDOM = 1900;
  localparam logic [15:0] NO_CHECK = 16'h8000;  // Sentinel: use the predictor.

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_x_coord = '0;
  logic signed [CW-1:0] in_y_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_angle;

  logic signed [15:0] angle_queue[$];
  int unsigned error_count = 0;
  int unsigned beats_seen = 0;
  bit stimulus_done = 1'b0;
  bit long_hold = 1'b0;

  fast_atan2_approx_unit #(
    .COORD_WIDTH(CW),
    .ANGLE_FRAC_BITS(FB)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_angle(out_angle)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Rounds pi * 2^frac from the 62-fraction-bit constant in the package.
  function automatic longint pi_scaled(int unsigned frac);
    logic [64:0] acc;
    acc = {1'b0, fatan_pkg::PI_Q62} + (65'd1 << (61 - frac));
    return longint'(acc >> (62 - frac));
  endfunction

  // Predicted angle for one coordinate pair, bit for bit.
  function automatic logic signed [15:0] predict_angle(logic signed [CW-1:0] xc,
                                                       logic signed [CW-1:0] yc);
    longint x, y, ax, ay, a, b, t, ang, pi_v, half_pi;
    logic [63:0] num, den, q, r;
    bit below_diag, neg_z;
    x = xc;
    y = yc;
    pi_v = pi_scaled(FB);
    half_pi = pi_scaled(FB - 1);
    if (x == 0) begin
      ang = (y > 0) ? half_pi : ((y == 0) ? 0 : -half_pi);
    end else begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      below_diag = ay < ax;
      neg_z = (x < 0) != (y < 0);
      a = ax;
      b = ay;
      while (a >= 65536 || b >= 65536) begin
        a = a >>> 1;
        b = b >>> 1;
      end
      num = 64'(a * b) << 16;
      if (below_diag) begin
        den = (64'(a * a) << 16) + 64'(fatan_pkg::COEF_Q16) * 64'(b * b);
      end else begin
        den = (64'(b * b) << 16) + 64'(fatan_pkg::COEF_Q16) * 64'(a * a);
      end
      // Long division for FB + 1 fraction bits, then round half up.
      q = num / den;
      r = num % den;
      for (int i = 0; i < FB + 1; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q[0] = 1'b1;
        end
      end
      t = longint'((q + 64'd1) >> 1);
      if (neg_z && y != 0) t = -t;
      if (below_diag) begin
        ang = t;
        if (x < 0) ang = (y < 0) ? ang - pi_v : ang + pi_v;
      end else begin
        ang = half_pi - t;
        if (y < 0) ang = ang - pi_v;
      end
    end
    if (ang > pi_v) ang = pi_v;
    if (ang < -pi_v) ang = -pi_v;
    return ang[15:0];
  endfunction

  task automatic report_mismatch(string what, logic signed [15:0] got,
                                 logic signed [15:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Sends one beat. The predictor runs when the beat is taken, and a typed-in
  // expectation is cross-checked against it.
  task automatic send_pair(logic signed [CW-1:0] xv, logic signed [CW-1:0] yv,
                           logic [15:0] typed);
    logic signed [15:0] want;
    in_valid <= 1'b1;
    in_x_coord <= xv;
    in_y_coord <= yv;
    do @(posedge clk); while (in_stall);
    want = predict_angle(xv, yv);
    if (typed != NO_CHECK && typed != want) report_mismatch("table row", typed, want);
    angle_queue.push_back(want);
  endtask

  // The directed table: pairs and, where obvious, their angle.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0] angle;
  } pair_row_t;

  pair_row_t directed[] = '{
    '{16'sd0, 16'sd0, 16'd0},
    '{16'sd0, 16'sd1, 16'd12868},
    '{16'sd0, -16'sd1, -16'sd12868},
    '{16'sd0, 16'sh7fff, 16'd12868},
    '{16'sd0, -16'sd32768, -16'sd12868},
    '{16'sd1, 16'sd0, 16'd0},
    '{16'sh7fff, 16'sd0, 16'd0},
    '{-16'sd1, 16'sd0, 16'd25736},
    '{-16'sd32768, 16'sd0, 16'd25736},
    '{-16'sd32768, -16'sd32768, NO_CHECK},
    '{16'sh7fff, 16'sh7fff, NO_CHECK},
    '{-16'sd32768, 16'sh7fff, NO_CHECK},
    '{16'sh7fff, -16'sd32768, NO_CHECK},
    '{16'sd1, 16'sd1, NO_CHECK},
    '{-16'sd1, -16'sd1, NO_CHECK},
    '{16'sd1, -16'sd1, NO_CHECK},
    '{-16'sd1, 16'sd1, NO_CHECK},
    '{16'sd100, 16'sd99, NO_CHECK},
    '{16'sd99, 16'sd100, NO_CHECK},
    '{-16'sd100, -16'sd99, NO_CHECK},
    '{-16'sd32768, -16'sd1, NO_CHECK},
    '{16'sd1, -16'sd32768, NO_CHECK},
    '{-16'sd5, 16'sd3, NO_CHECK},
    '{16'sh5555, -16'sh2aaa, NO_CHECK}
  };

  // Random pair: mostly full range, some near the diagonal, some small, some on an axis.
  task automatic random_pair(output logic signed [CW-1:0] xv,
                             output logic signed [CW-1:0] yv);
    int unsigned pick;
    int m;
    pick = $urandom_range(9);
    xv = CW'($urandom);
    yv = CW'($urandom);
    if (pick < 2) begin
      m = int'($urandom_range(32767));
      xv = $urandom_range(1) ? CW'(m) : CW'(-m);
      m = m + int'($urandom_range(4)) - 2;
      if (m > 32767) m = 32767;
      if (m < 0) m = 0;
      yv = $urandom_range(1) ? CW'(m) : CW'(-m);
    end else if (pick < 4) begin
      xv = CW'(int'($urandom_range(16)) - 8);
      yv = CW'(int'($urandom_range(16)) - 8);
    end else if (pick == 4) begin
      if ($urandom_range(1)) xv = '0;
      else yv = '0;
    end
  endtask

  // Sender: directed table, then random pairs in bursts with gaps.
  initial begin
    logic signed [CW-1:0] xv, yv;
    int unsigned burst;
    int unsigned sent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_pair(directed[i].x, directed[i].y, directed[i].angle);
    in_valid <= 1'b0;
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(40, 1);
      for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
        random_pair(xv, yv);
        send_pair(xv, yv, NO_CHECK);
        sent++;
      end
      // Gaps are skipped now and then, so bursts also run back to back.
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: random stall pattern, quiet stretches, and one long hold-off
  // once a few hundred beats have been checked, so that the pipeline fills
  // and the input side must stall.
  initial begin
    int unsigned mode;
    @(posedge rst_n);
    forever begin
      if (!long_hold && beats_seen > 300) begin
        long_hold = 1'b1;
        out_stall <= 1'b1;
        repeat (LATENCY * 4) @(posedge clk);
      end
      mode = $urandom_range(3);
      for (int k = 0; k < 32; k++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3) == 0);
          2: out_stall <= ($urandom_range(1) == 0);
          default: out_stall <= ($urandom_range(7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (angle_queue.size() == 0) begin
        report_mismatch("unexpected beat", out_angle, 16'sd0);
      end else begin
        logic signed [15:0] want;
        want = angle_queue.pop_front();
        if (out_angle !== want) report_mismatch("angle", out_angle, want);
      end
    end
  end

  // Drain: wait for every angle, then let the pipeline settle.
  initial begin
    wait (stimulus_done);
    wait (angle_queue.size() == 0);
    repeat (LATENCY * 3) @(posedge clk);
    if (error_count == 0 && angle_queue.size() == 0) begin
      $display("** fast_atan2_approx_unit: PASSED **");
    end else begin
      $display("** fast_atan2_approx_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #400000;
    $display("timeout waiting for results");
    $display("** fast_atan2_approx_unit: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
sv/fatan_pkg.sv
sv/fatan_div_stage.sv
sv/fast_atan2_approx_unit.sv
bench/fast_atan2_approx_unit_tb.sv
